// File: rtl/core/cdq_pkg.sv
// Shared types and codes for the circular deque unit.
// No dependencies.
package cdq_pkg;

   localparam int ModeW   = 3;
   localparam int StatusW = 2;
   localparam int ValueW  = 32;
   localparam int CountOutW = 8;

   localparam logic [ModeW-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [ModeW-1:0] MODE_PUSH_REAR  = 3'd1;
   localparam logic [ModeW-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [ModeW-1:0] MODE_POP_REAR   = 3'd3;
   localparam logic [ModeW-1:0] MODE_PEEK_FRONT = 3'd4;
   localparam logic [ModeW-1:0] MODE_PEEK_REAR  = 3'd5;

   localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
   localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
   localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                write;
      logic                read;
      logic [StatusW-1:0]  status;
   } cdq_ctl_type;

   localparam int CtlW = $bits(cdq_ctl_type);

endpackage

// File: rtl/core/cdq_front.sv
// Front end: accepts requests, keeps head/tail/count, classifies each request
// into a storage command. Depends on cdq_pkg.
module cdq_front #(
   parameter int DEPTH = 128,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cdq_pkg::ModeW-1:0]       req_mode,
   input  logic signed [cdq_pkg::ValueW-1:0] req_push_value,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output cdq_pkg::cdq_ctl_type            cmd_ctl,
   output logic [AW-1:0]                   cmd_addr,
   output logic [cdq_pkg::ValueW-1:0]      cmd_value,
   output logic [CW-1:0]                   cmd_count
);
   import cdq_pkg::*;

   localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          is_push, is_pop, is_peek, is_front, full, empty, xfer;
   logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign xfer      = req_valid && cmd_ready;

   assign is_push  = (req_mode == MODE_PUSH_FRONT) || (req_mode == MODE_PUSH_REAR);
   assign is_pop   = (req_mode == MODE_POP_FRONT) || (req_mode == MODE_POP_REAR);
   assign is_peek  = (req_mode == MODE_PEEK_FRONT) || (req_mode == MODE_PEEK_REAR);
   assign is_front = (req_mode == MODE_PUSH_FRONT) || (req_mode == MODE_POP_FRONT) ||
                     (req_mode == MODE_PEEK_FRONT);
   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);

   assign head_inc = (head_ff == LastIdx) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? LastIdx : head_ff - 1'b1;
   assign tail_inc = (tail_ff == LastIdx) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? LastIdx : tail_ff - 1'b1;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      cmd_ctl   = '0;
      cmd_addr  = '0;
      cmd_value = '0;
      if (is_push) begin
         if (full) begin
            cmd_ctl.status = STATUS_FULL;
         end else begin
            cmd_ctl.write = 1'b1;
            cmd_value     = req_push_value;
            count_in      = count_ff + 1'b1;
            if (empty) begin
               head_in = '0;
               tail_in = '0;
            end else if (is_front) begin
               head_in  = head_dec;
               cmd_addr = head_dec;
            end else begin
               tail_in  = tail_inc;
               cmd_addr = tail_inc;
            end
         end
      end else if (is_pop || is_peek) begin
         if (empty) begin
            cmd_ctl.status = STATUS_EMPTY;
         end else begin
            cmd_ctl.read = 1'b1;
            cmd_addr     = is_front ? head_ff : tail_ff;
            if (is_pop) begin
               count_in = count_ff - 1'b1;
               if (count_ff == CW'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (is_front) begin
                  head_in = head_inc;
               end else begin
                  tail_in = tail_dec;
               end
            end
         end
      end
      cmd_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (xfer) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/core/cdq_cmd_fifo.sv
// Two-entry command queue between front and back ends.
// Depends on nothing; width set by the instantiating module.
module cdq_cmd_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: rtl/core/cdq_back.sv
// Back end: entry store and response register; executes one command per cycle
// while the response register is empty or being taken. Depends on cdq_pkg.
module cdq_back #(
   parameter int DEPTH = 128,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   output logic                                cmd_ready,
   input  cdq_pkg::cdq_ctl_type                cmd_ctl,
   input  logic [AW-1:0]                       cmd_addr,
   input  logic [cdq_pkg::ValueW-1:0]          cmd_value,
   input  logic [CW-1:0]                       cmd_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cdq_pkg::ValueW-1:0]   rsp_item_value,
   output logic [cdq_pkg::CountOutW-1:0]       rsp_item_count,
   output logic [cdq_pkg::StatusW-1:0]         rsp_status
);
   import cdq_pkg::*;

   logic [ValueW-1:0]   entries [DEPTH];
   logic [ValueW-1:0]   rd_data_ff, value_ff;
   logic [CW-1:0]       count_ff;
   logic [StatusW-1:0]  status_ff;
   logic                sel_rd_ff, valid_ff, valid_in, take;
   logic [CW+CountOutW-1:0] count_ext;

   assign cmd_ready = !valid_ff || rsp_ready;
   assign take      = cmd_valid && cmd_ready;
   assign valid_in  = take || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         value_ff  <= cmd_value;
         count_ff  <= cmd_count;
         status_ff <= cmd_ctl.status;
         sel_rd_ff <= cmd_ctl.read;
      end
   end

   always_ff @(posedge clock) begin
      if (take && cmd_ctl.write) begin
         entries[cmd_addr] <= cmd_value;
      end
      if (take && cmd_ctl.read) begin
         rd_data_ff <= entries[cmd_addr];
      end
   end

   assign count_ext      = {{CountOutW{1'b0}}, count_ff};
   assign rsp_valid      = valid_ff;
   assign rsp_item_value = sel_rd_ff ? rd_data_ff : value_ff;
   assign rsp_item_count = count_ext[CountOutW-1:0];
   assign rsp_status     = status_ff;

endmodule

// File: rtl/core/circular_deque_unit.sv
// Circular deque unit: top level joining front end, command queue and back end.
// Depends on cdq_pkg, cdq_front, cdq_cmd_fifo, cdq_back.
//
// Takes one request per clock cycle while responses are taken as they appear,
// and returns one response per request, in order. The transfer edge writes
// the command into the command queue, from which the back end moves it
// through the entry store's registered read into the response register.
// While rsp_ready stays low, the response register and the two-entry command
// queue hold three requests, and then req_ready drops. It rises again right
// after the waiting response transfers. Pointer and count updates happen in
// the front end at request transfer, so back-to-back requests see each
// other's effects. The entry store is not cleared at reset and needs no
// clearing pass; only entries that were pushed are ever read.
module circular_deque_unit #(
   parameter int DEPTH = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cdq_pkg::ModeW-1:0]         req_mode,
   input  logic signed [cdq_pkg::ValueW-1:0] req_push_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [cdq_pkg::ValueW-1:0] rsp_item_value,
   output logic [cdq_pkg::CountOutW-1:0]     rsp_item_count,
   output logic [cdq_pkg::StatusW-1:0]       rsp_status
);
   import cdq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int QW = CtlW + AW + ValueW + CW;

   logic              f_valid, f_ready, b_valid, b_ready;
   cdq_ctl_type       f_ctl, b_ctl;
   logic [AW-1:0]     f_addr, b_addr;
   logic [ValueW-1:0] f_value, b_value;
   logic [CW-1:0]     f_count, b_count;
   logic [QW-1:0]     q_in, q_out;

   cdq_front #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_push_value (req_push_value),
      .cmd_valid      (f_valid),
      .cmd_ready      (f_ready),
      .cmd_ctl        (f_ctl),
      .cmd_addr       (f_addr),
      .cmd_value      (f_value),
      .cmd_count      (f_count)
   );

   assign q_in = {f_ctl, f_addr, f_value, f_count};

   cdq_cmd_fifo #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (q_in),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (q_out)
   );

   assign {b_ctl, b_addr, b_value, b_count} = q_out;

   cdq_back #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (b_valid),
      .cmd_ready      (b_ready),
      .cmd_ctl        (b_ctl),
      .cmd_addr       (b_addr),
      .cmd_value      (b_value),
      .cmd_count      (b_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item_value (rsp_item_value),
      .rsp_item_count (rsp_item_count),
      .rsp_status     (rsp_status)
   );

endmodule
